FILE: src/rfr_pkg.sv
// ---------------------------------------------------------------------------
// rfr_pkg: shared constants for the radio fragment reassembler
// Field widths, store geometry and configuration register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

  // Frame header and payload field widths
  localparam int HDR_W      = 8;
  localparam int WORD_W     = 64;
  localparam int TAIL_W     = 32;
  localparam int COUNT_W    = 4;

  // Fragment store geometry
  localparam int MAX_FRAGMENTS  = 16;
  localparam int FRAG_IDX_W     = 4;   // index into the fragment slots
  localparam int FRAG_CNT_W     = 5;   // holds 0..MAX_FRAGMENTS
  localparam int SLOT_WORDS     = 4;
  localparam int SLOT_W         = 2;   // word within a slot
  localparam int STORE_DEPTH    = MAX_FRAGMENTS * SLOT_WORDS;
  localparam int STORE_AW       = FRAG_IDX_W + SLOT_W;
  localparam int FRAGMENT_BYTES = 28;
  localparam int LEN_W          = 5;   // holds 0..FRAGMENT_BYTES
  localparam int TOTAL_W        = 9;   // holds MAX_FRAGMENTS * FRAGMENT_BYTES

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_BROKEN     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK_BYTES = 1'd1;
  localparam logic [CFG_DATA_W-1:0] MAX_BLOCK_BYTES_RST = 10'd512;

  typedef logic [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

FILE: src/rfr_frame_if.sv
// ---------------------------------------------------------------------------
// rfr_frame_if: received frame channel
// One item is one parsed radio frame: header fields and 28 payload bytes.
// ---------------------------------------------------------------------------
`default_nettype none

interface rfr_frame_if;
  logic                        valid;
  logic                        ready;
  logic [rfr_pkg::HDR_W-1:0]   block_number;
  logic [rfr_pkg::HDR_W-1:0]   fragment_index;
  logic [rfr_pkg::HDR_W-1:0]   fragment_total;
  logic [rfr_pkg::HDR_W-1:0]   payload_size;
  logic [rfr_pkg::WORD_W-1:0]  payload_word0;
  logic [rfr_pkg::WORD_W-1:0]  payload_word1;
  logic [rfr_pkg::WORD_W-1:0]  payload_word2;
  logic [rfr_pkg::TAIL_W-1:0]  payload_tail;

  modport source (
    output valid, block_number, fragment_index, fragment_total, payload_size,
           payload_word0, payload_word1, payload_word2, payload_tail,
    input  ready
  );

  modport sink (
    input  valid, block_number, fragment_index, fragment_total, payload_size,
           payload_word0, payload_word1, payload_word2, payload_tail,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/rfr_word_if.sv
// ---------------------------------------------------------------------------
// rfr_word_if: reassembled block output channel
// One item is up to 8 bytes of a block with count, end and status flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface rfr_word_if;
  logic                         valid;
  logic                         ready;
  logic [rfr_pkg::WORD_W-1:0]   data_word;
  logic [rfr_pkg::COUNT_W-1:0]  byte_count;
  logic                         last_word;
  logic                         block_ok;

  modport source (
    output valid, data_word, byte_count, last_word, block_ok,
    input  ready
  );

  modport sink (
    input  valid, data_word, byte_count, last_word, block_ok,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/rfr_ram.sv
// ---------------------------------------------------------------------------
// rfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ---------------------------------------------------------------------------
`default_nettype none

module rfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/radio_fragment_reassembler_unit.sv
// ---------------------------------------------------------------------------
// radio_fragment_reassembler_unit: reassembles fragmented radio blocks
//
// Input channel "frames" carries one parsed frame per item. Output channel
// "words" carries the reassembled block as up to 8-byte items, first byte in
// the low bits, with last_word on the final item and block_ok clear for the
// truncated prefix of a broken block. Registers drop_broken and
// max_block_bytes are written through cfg_wr_en / cfg_index / cfg_data.
//
// Sequencing: one frame at a time. A stored, non-final fragment is accepted,
// decoded and written as four store writes into the 64x64 fragment RAM. A
// final fragment adds a length scan over its fragments, then a read step and
// a data step per stored payload word through the single RAM read port, plus
// a flush step for a trailing partial word. A single-fragment frame is walked
// from the captured payload. Repeats and out-of-range indexes end at decode.
//
// Reset clears the fragment lengths, block tracking, output valid and sets
// drop_broken=1, max_block_bytes=512; the RAM needs no clearing. A stall on
// "words" holds the walk in place; the output register keeps its item.
// ---------------------------------------------------------------------------
`default_nettype none

module radio_fragment_reassembler_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  rfr_frame_if.sink                             frames,
  rfr_word_if.source                            words
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_STORE  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_DATA   = 3'd5;
  localparam logic [2:0] ST_FLUSH  = 3'd6;

  localparam int ACC_W  = 56;   // at most 7 bytes wait between items
  localparam int COMB_W = 120;  // 7 waiting bytes plus 8 new ones

  logic [2:0] state;

  // configuration
  logic                              drop_broken;
  logic [rfr_pkg::CFG_DATA_W-1:0]    max_block_bytes;

  // block tracking
  logic [rfr_pkg::HDR_W-1:0]         current_block;
  logic [rfr_pkg::HDR_W-1:0]         expected_fragments;
  logic                              block_delivered;

  // captured frame
  logic [rfr_pkg::HDR_W-1:0]         r_bn;
  logic [rfr_pkg::HDR_W-1:0]         r_fi;
  logic [rfr_pkg::HDR_W-1:0]         r_ft;
  logic [rfr_pkg::LEN_W-1:0]         r_sz;
  rfr_pkg::word_t                    r_pay [rfr_pkg::SLOT_WORDS];

  // fragment lengths, zero means missing
  logic [rfr_pkg::LEN_W-1:0]         lens [rfr_pkg::MAX_FRAGMENTS];
  logic                              lens_clr;
  logic                              lens_wr;

  // walk state
  logic [rfr_pkg::FRAG_CNT_W-1:0]    frag;
  logic [rfr_pkg::SLOT_W-1:0]        wsel;
  logic [rfr_pkg::FRAG_CNT_W-1:0]    nfrag;
  logic [rfr_pkg::TOTAL_W-1:0]       total;
  logic [rfr_pkg::TOTAL_W-1:0]       rem;
  logic                              pass;
  logic                              blk_ok;
  logic [ACC_W-1:0]                  acc;
  logic [2:0]                        cnt;

  // output register
  logic                              out_valid;
  rfr_pkg::word_t                    out_data;
  logic [rfr_pkg::COUNT_W-1:0]       out_count;
  logic                              out_last;
  logic                              out_ok;
  logic                              out_load;

  // RAM ports
  logic                              ram_wr;
  logic [rfr_pkg::STORE_AW-1:0]      ram_waddr;
  logic                              ram_rd;
  logic [rfr_pkg::STORE_AW-1:0]      ram_raddr;
  rfr_pkg::word_t                    ram_q;

  // decode terms
  logic                              is_repeat;
  logic                              is_new;
  logic                              more_to_come;

  // scan terms
  logic [rfr_pkg::LEN_W-1:0]         scan_len;
  logic [rfr_pkg::CFG_DATA_W-1:0]    scan_sum;
  logic                              scan_end;
  logic                              scan_bad;

  // walk datapath
  logic [rfr_pkg::LEN_W-1:0]         cur_len;
  logic [rfr_pkg::LEN_W-1:0]         fr_left;
  logic [rfr_pkg::COUNT_W-1:0]       take;
  rfr_pkg::word_t                    src_word;
  rfr_pkg::word_t                    masked;
  logic [COMB_W-1:0]                 comb;
  logic [rfr_pkg::COUNT_W-1:0]       ccount;
  logic                              emit8;
  logic                              emit_rem;
  logic                              frag_done;
  logic                              block_end;
  logic                              out_free;
  logic [rfr_pkg::HDR_W-1:0]         sz_in;

  assign frames.ready = (state == ST_IDLE);
  assign out_free     = !out_valid || words.ready;

  assign words.valid      = out_valid;
  assign words.data_word  = out_data;
  assign words.byte_count = out_count;
  assign words.last_word  = out_last;
  assign words.block_ok   = out_ok;

  // fragment store
  rfr_ram #(
    .WIDTH (rfr_pkg::WORD_W),
    .DEPTH (rfr_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ram_waddr),
    .wr_data (r_pay[wsel]),
    .rd_en   (ram_rd),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  assign ram_wr    = (state == ST_STORE);
  assign ram_waddr = {r_fi[rfr_pkg::FRAG_IDX_W-1:0], wsel};
  assign ram_rd    = (state == ST_READ) && !pass;
  assign ram_raddr = {frag[rfr_pkg::FRAG_IDX_W-1:0], wsel};

  // size saturation at capture
  assign sz_in = (frames.payload_size > rfr_pkg::HDR_W'(rfr_pkg::FRAGMENT_BYTES))
               ? rfr_pkg::HDR_W'(rfr_pkg::FRAGMENT_BYTES) : frames.payload_size;

  // frame classification
  always_comb begin
    is_repeat    = (r_bn == current_block) && block_delivered;
    is_new       = (r_bn != current_block);
    more_to_come = (expected_fragments != '0) &&
                   ({1'b0, r_fi} + 9'd1 < {1'b0, expected_fragments});
  end

  // length scan step; entries past the store count as missing
  always_comb begin
    scan_len = frag[rfr_pkg::FRAG_CNT_W-1] ? '0 : lens[frag[rfr_pkg::FRAG_IDX_W-1:0]];
    scan_sum = {1'b0, total} + rfr_pkg::CFG_DATA_W'(scan_len);
    scan_end = ({3'b0, frag} >= expected_fragments);
    // total stays below 449, so the 64-word output limit never binds
    scan_bad = (scan_len == '0) || (scan_sum >= max_block_bytes);
  end

  // byte packer: append the current word's bytes behind the waiting ones
  always_comb begin
    cur_len  = pass ? r_sz : lens[frag[rfr_pkg::FRAG_IDX_W-1:0]];
    fr_left  = cur_len - {wsel, 3'b000};
    take     = (fr_left > 5'd8) ? 4'd8 : fr_left[3:0];
    src_word = pass ? r_pay[wsel] : ram_q;
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < take) ? src_word[8*b +: 8] : 8'h00;
    end
    comb      = ({56'b0, masked} << {cnt, 3'b000}) | {64'b0, acc};
    ccount    = {1'b0, cnt} + take;
    emit8     = ccount[3];
    emit_rem  = !ccount[3] && (rfr_pkg::TOTAL_W'(ccount) == rem);
    frag_done = (fr_left <= 5'd8);
    block_end = frag_done && (frag + 5'd1 == nfrag);
  end

  // an item enters the output register
  assign out_load = out_free &&
                    (((state == ST_DATA) && (emit8 || emit_rem)) || (state == ST_FLUSH));

  // fragment length table; a write to a fresh block wins over its clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rfr_pkg::MAX_FRAGMENTS; i++) lens[i] <= '0;
    end else begin
      for (int i = 0; i < rfr_pkg::MAX_FRAGMENTS; i++) begin
        if (lens_wr && (r_fi[rfr_pkg::FRAG_IDX_W-1:0] == rfr_pkg::FRAG_IDX_W'(i))) begin
          lens[i] <= r_sz;
        end else if (lens_clr) begin
          lens[i] <= '0;
        end
      end
    end
  end

  assign lens_clr = (state == ST_DECODE) && !is_repeat && is_new;
  assign lens_wr  = (state == ST_DECODE) && !is_repeat && (r_ft != 8'd1) &&
                    (r_fi < rfr_pkg::HDR_W'(rfr_pkg::MAX_FRAGMENTS));

  // frame capture
  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      r_bn     <= frames.block_number;
      r_fi     <= frames.fragment_index;
      r_ft     <= frames.fragment_total;
      r_sz     <= sz_in[rfr_pkg::LEN_W-1:0];
      r_pay[0] <= frames.payload_word0;
      r_pay[1] <= frames.payload_word1;
      r_pay[2] <= frames.payload_word2;
      r_pay[3] <= {32'b0, frames.payload_tail};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_broken     <= 1'b1;
      max_block_bytes <= rfr_pkg::MAX_BLOCK_BYTES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rfr_pkg::REG_DROP_BROKEN:     drop_broken     <= cfg_data[0];
        rfr_pkg::REG_MAX_BLOCK_BYTES: max_block_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      current_block      <= '0;
      expected_fragments <= '0;
      block_delivered    <= 1'b0;
      out_valid          <= 1'b0;
      frag               <= '0;
      wsel               <= '0;
      nfrag              <= '0;
      total              <= '0;
      rem                <= '0;
      pass               <= 1'b0;
      blk_ok             <= 1'b0;
      acc                <= '0;
      cnt                <= '0;
    end else begin
      // output register loads a new item or drains when taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (frames.valid) begin
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          wsel <= '0;
          frag <= '0;
          acc  <= '0;
          cnt  <= '0;
          if (is_repeat) begin
            state <= ST_IDLE;
          end else begin
            if (is_new) begin
              if (r_ft != 8'd1) begin
                block_delivered <= 1'b0;
              end
              current_block      <= r_bn;
              expected_fragments <= r_ft;
            end
            priority if (r_ft == 8'd1) begin
              // single fragment: send the payload straight out
              block_delivered <= 1'b1;
              pass            <= 1'b1;
              blk_ok          <= 1'b1;
              nfrag           <= 5'd1;
              rem             <= rfr_pkg::TOTAL_W'(r_sz);
              state           <= (r_sz == '0) ? ST_IDLE : ST_READ;
            end else if (r_fi >= rfr_pkg::HDR_W'(rfr_pkg::MAX_FRAGMENTS)) begin
              state <= ST_IDLE;
            end else begin
              pass  <= 1'b0;
              state <= ST_STORE;
            end
          end
        end

        ST_STORE: begin
          wsel <= wsel + 2'd1;
          if (wsel == 2'd3) begin
            total <= '0;
            frag  <= '0;
            state <= more_to_come ? ST_IDLE : ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (scan_end || scan_bad) begin
            blk_ok <= scan_end;
            nfrag  <= frag;
            frag   <= '0;
            wsel   <= '0;
            rem    <= total;
            if (drop_broken && !scan_end) begin
              state <= ST_IDLE;
            end else begin
              block_delivered <= 1'b1;
              state           <= (total == '0) ? ST_IDLE : ST_READ;
            end
          end else begin
            total <= scan_sum[rfr_pkg::TOTAL_W-1:0];
            frag  <= frag + 5'd1;
          end
        end

        ST_READ: begin
          state <= ST_DATA;
        end

        ST_DATA: begin
          if (out_free) begin
            priority if (emit8) begin
              out_data  <= comb[63:0];
              out_count <= 4'd8;
              out_last  <= (rem == 9'd8);
              out_ok    <= blk_ok;
              acc       <= comb[COMB_W-1:64];
              cnt       <= ccount[2:0];
              rem       <= rem - 9'd8;
            end else if (emit_rem) begin
              out_data  <= comb[63:0];
              out_count <= ccount;
              out_last  <= 1'b1;
              out_ok    <= blk_ok;
              acc       <= '0;
              cnt       <= '0;
              rem       <= '0;
            end else begin
              acc <= comb[ACC_W-1:0];
              cnt <= ccount[2:0];
            end
            // advance through words and fragments
            if (block_end) begin
              state <= (emit8 && (ccount[2:0] != 3'd0)) ? ST_FLUSH : ST_IDLE;
            end else begin
              state <= ST_READ;
              if (frag_done) begin
                frag <= frag + 5'd1;
                wsel <= '0;
              end else begin
                wsel <= wsel + 2'd1;
              end
            end
          end
        end

        ST_FLUSH: begin
          if (out_free) begin
            out_data  <= {8'b0, acc};
            out_count <= {1'b0, cnt};
            out_last  <= 1'b1;
            out_ok    <= blk_ok;
            acc       <= '0;
            cnt       <= '0;
            rem       <= '0;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/radio_fragment_reassembler_unit_chk.sv
// ---------------------------------------------------------------------------
// radio_fragment_reassembler_unit_chk: scoreboard for the fragment reassembler
// Follows register writes and accepted frames with its own copy of the
// fragment store. Each accepted frame queues the words it should produce,
// and every word item that leaves the block is checked field by field
// against the oldest queued word.
// ---------------------------------------------------------------------------
module radio_fragment_reassembler_unit_chk
  import rfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rfr_frame_if                  frames,
  rfr_word_if                   words,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_BYTES = 512;

  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic               last_word;
    logic               block_ok;
  } block_word_t;

  block_word_t          expected_words[$];

  // Mirror of the block state
  word_t                slot_words [STORE_DEPTH];
  logic [LEN_W-1:0]     slot_len   [MAX_FRAGMENTS];
  logic [HDR_W-1:0]     cur_block;
  logic [HDR_W-1:0]     want_frags;
  logic                 delivered;
  logic                 drop_broken;
  logic [CFG_DATA_W-1:0] max_bytes;
  logic [7:0]           block_bytes [OUT_BYTES];

  // Cut the first n bytes of block_bytes into word items
  task automatic queue_block_words(input int n, input logic ok);
    block_word_t w;
    int          pos;
    int          take;
    int          b;
    pos = 0;
    while (pos < n) begin
      take = (n - pos > 8) ? 8 : n - pos;
      w = '0;
      for (b = 0; b < take; b++) w.data_word[8*b +: 8] = block_bytes[pos + b];
      pos += take;
      w.byte_count = COUNT_W'(take);
      w.last_word  = (pos >= n);
      w.block_ok   = ok;
      expected_words.push_back(w);
    end
  endtask

  // One accepted frame: update the mirror, queue the words it releases
  task automatic reassemble_frame(input logic [HDR_W-1:0] bn, input logic [HDR_W-1:0] fi,
                                  input logic [HDR_W-1:0] ft, input logic [HDR_W-1:0] size_raw,
                                  input word_t w0, input word_t w1, input word_t w2,
                                  input logic [TAIL_W-1:0] tail);
    word_t pay [SLOT_WORDS];
    int    sz;
    int    idx;
    int    total;
    int    len;
    int    i;
    int    k;
    logic  ok;
    sz     = (int'(size_raw) > FRAGMENT_BYTES) ? FRAGMENT_BYTES : int'(size_raw);
    idx    = int'(fi);
    pay[0] = w0;
    pay[1] = w1;
    pay[2] = w2;
    pay[3] = {32'd0, tail};

    // repeat of a block already handed out
    if (bn == cur_block && delivered) return;

    // new block number restarts the store
    if (bn != cur_block) begin
      for (i = 0; i < MAX_FRAGMENTS; i++) slot_len[i] = '0;
      delivered  = 1'b0;
      cur_block  = bn;
      want_frags = ft;
    end

    // single-fragment block goes straight out
    if (ft == 8'd1) begin
      delivered = 1'b1;
      for (k = 0; k < sz; k++) block_bytes[k] = pay[k / 8][8*(k % 8) +: 8];
      queue_block_words(sz, 1'b1);
      return;
    end

    if (idx >= MAX_FRAGMENTS) return;

    for (k = 0; k < SLOT_WORDS; k++) slot_words[idx*SLOT_WORDS + k] = pay[k];
    slot_len[idx] = LEN_W'(sz);

    if (want_frags != 0 && idx + 1 < int'(want_frags)) return;

    // walk the kept fragments in order
    total = 0;
    ok    = 1'b1;
    for (i = 0; i < int'(want_frags); i++) begin
      len = 0;
      if (i < MAX_FRAGMENTS) len = int'(slot_len[i]);
      if (len == 0 || total + len >= int'(max_bytes) || total + len > OUT_BYTES) begin
        ok = 1'b0;
        break;
      end
      for (k = 0; k < len; k++)
        block_bytes[total + k] = slot_words[i*SLOT_WORDS + k/8][8*(k % 8) +: 8];
      total += len;
    end

    if (drop_broken && !ok) return;
    delivered = 1'b1;
    queue_block_words(total, ok);
  endtask

  always @(posedge clk) begin
    block_word_t exp_w;
    int          i;
    if (rst) begin
      for (i = 0; i < MAX_FRAGMENTS; i++) slot_len[i] = '0;
      cur_block   = '0;
      want_frags  = '0;
      delivered   = 1'b0;
      drop_broken = 1'b1;
      max_bytes   = MAX_BLOCK_BYTES_RST;
      expected_words.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DROP_BROKEN:     drop_broken = cfg_data[0];
          REG_MAX_BLOCK_BYTES: max_bytes   = cfg_data;
          default: ;
        endcase
      end

      if (frames.valid && frames.ready)
        reassemble_frame(frames.block_number, frames.fragment_index, frames.fragment_total,
                         frames.payload_size, frames.payload_word0, frames.payload_word1,
                         frames.payload_word2, frames.payload_tail);

      // compare outgoing word items
      if (words.valid && words.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word item: data_word %h byte_count %0d",
                 words.data_word, words.byte_count);
          errors++;
        end else begin
          exp_w = expected_words[0];
          expected_words.delete(0);
          if (words.data_word !== exp_w.data_word) begin
            $error("data_word: expected %h, actual %h", exp_w.data_word, words.data_word);
            errors++;
          end
          if (words.byte_count !== exp_w.byte_count) begin
            $error("byte_count: expected %0d, actual %0d", exp_w.byte_count, words.byte_count);
            errors++;
          end
          if (words.last_word !== exp_w.last_word) begin
            $error("last_word: expected %b, actual %b", exp_w.last_word, words.last_word);
            errors++;
          end
          if (words.block_ok !== exp_w.block_ok) begin
            $error("block_ok: expected %b, actual %b", exp_w.block_ok, words.block_ok);
            errors++;
          end
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

FILE: verif/radio_fragment_reassembler_unit_tb.sv
// ---------------------------------------------------------------------------
// radio_fragment_reassembler_unit_tb: stimulus and verdict for the reassembler
// A short directed run covers the corner cases of block handling, then
// random blocks (clean, with gaps, reordered, duplicated, repeated) and
// noise frames run under several register settings and idle patterns.
// One phase holds the output off long enough to back up the input.
// ---------------------------------------------------------------------------
module radio_fragment_reassembler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfr_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {FLAW_NONE, FLAW_MISSING, FLAW_SHUFFLED, FLAW_DUPLICATE,
                    FLAW_REPEAT} block_flaw_t;

  localparam int PHASE_ITEMS  = 60;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rfr_frame_if frames ();
  rfr_word_if  words ();

  idle_mode_t       idle_mode = IDLE_NONE;
  bit               hold_req  = 1'b0;
  int               items_sent = 0;
  int               fail_count;
  int               pending_words;
  logic [HDR_W-1:0] next_block;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radio_fragment_reassembler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frames    (frames),
    .words     (words)
  );

  radio_fragment_reassembler_unit_chk chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frames    (frames),
    .words     (words),
    .errors    (fail_count),
    .pending   (pending_words)
  );

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly legal sizes, some empty and some oversized
  function automatic logic [HDR_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 8'd0;
    if (r < 10) return HDR_W'($urandom_range(FRAGMENT_BYTES + 1, 255));
    if (r < 25) return HDR_W'(FRAGMENT_BYTES);
    return HDR_W'($urandom_range(1, FRAGMENT_BYTES));
  endfunction

  function automatic int pick_frag_total();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 1;
    if (r < 25) return MAX_FRAGMENTS;
    if (r < 28) return 0;
    if (r < 32) return int'($urandom_range(MAX_FRAGMENTS + 1, 255));
    if (r < 45) return int'($urandom_range(7, MAX_FRAGMENTS - 1));
    return int'($urandom_range(2, 6));
  endfunction

  // Output side: random stalls, plus a long hold-off on request
  initial begin
    bit stall;
    words.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        words.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case (idle_mode)
        IDLE_RECV: stall = ($urandom_range(99) < 67);
        IDLE_BOTH: stall = ($urandom_range(99) < 11);
        default:   stall = 1'b0;
      endcase
      words.ready <= !stall;
    end
  end

  // Drive one frame item and wait until it is taken
  task automatic send_frame(input logic [HDR_W-1:0] bn, input logic [HDR_W-1:0] fi,
                            input logic [HDR_W-1:0] ft, input logic [HDR_W-1:0] sz,
                            input word_t w0, input word_t w1, input word_t w2,
                            input logic [TAIL_W-1:0] tail);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 67 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < idle_pct) begin
      frames.valid <= 1'b0;
      @(posedge clk);
    end
    frames.valid          <= 1'b1;
    frames.block_number   <= bn;
    frames.fragment_index <= fi;
    frames.fragment_total <= ft;
    frames.payload_size   <= sz;
    frames.payload_word0  <= w0;
    frames.payload_word1  <= w1;
    frames.payload_word2  <= w2;
    frames.payload_tail   <= tail;
    @(posedge clk);
    while (!frames.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frag(input logic [HDR_W-1:0] bn, input logic [HDR_W-1:0] fi,
                           input logic [HDR_W-1:0] ft, input logic [HDR_W-1:0] sz);
    send_frame(bn, fi, ft, sz, rand_word(), rand_word(), rand_word(), $urandom);
  endtask

  // One block, clean or with a flaw in its fragment sequence
  task automatic send_block(input logic [HDR_W-1:0] bn, input int total_frags,
                            input block_flaw_t flaw);
    int order[$];
    int count;
    int j;
    int a;
    int tmp;
    count = (total_frags == 0) ? 1 :
            (total_frags > MAX_FRAGMENTS) ? MAX_FRAGMENTS : total_frags;
    for (j = 0; j < count; j++) order.push_back(j);
    if (total_frags <= 1) order[0] = int'($urandom_range(255));
    case (flaw)
      FLAW_MISSING:
        if (count > 1) order.delete(int'($urandom_range(count - 2)));
      FLAW_SHUFFLED:
        for (j = 0; j < count; j++) begin
          a        = int'($urandom_range(count - 1));
          tmp      = order[j];
          order[j] = order[a];
          order[a] = tmp;
        end
      FLAW_DUPLICATE:
        order.insert(int'($urandom_range(count - 1)), order[$urandom_range(count - 1)]);
      default: ;
    endcase
    foreach (order[j]) send_frag(bn, HDR_W'(order[j]), HDR_W'(total_frags), pick_size());
    if (flaw == FLAW_REPEAT)
      send_frag(bn, HDR_W'($urandom_range(count - 1)), HDR_W'(total_frags), pick_size());
  endtask

  task automatic run_random(input int n_items);
    int          stop_at;
    int          r;
    block_flaw_t flaw;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // noise: every header field anywhere in range
        send_frame(HDR_W'($urandom), HDR_W'($urandom), HDR_W'($urandom), HDR_W'($urandom),
                   rand_word(), rand_word(), rand_word(), $urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 70)      flaw = FLAW_NONE;
        else if (r < 78) flaw = FLAW_MISSING;
        else if (r < 86) flaw = FLAW_SHUFFLED;
        else if (r < 92) flaw = FLAW_DUPLICATE;
        else             flaw = FLAW_REPEAT;
        // now and then keep the previous block number
        if ($urandom_range(99) >= 5) next_block++;
        send_block(next_block, pick_frag_total(), flaw);
      end
    end
  endtask

  // Block is idle: nothing expected and any silent walk has finished
  task automatic settle();
    frames.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic drop, input logic [CFG_DATA_W-1:0] max_block);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DROP_BROKEN;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, drop};
    @(posedge clk);
    cfg_index <= REG_MAX_BLOCK_BYTES;
    cfg_data  <= max_block;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int         p;
    idle_mode_t modes [4];
    modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

    frames.valid          <= 1'b0;
    frames.block_number   <= '0;
    frames.fragment_index <= '0;
    frames.fragment_total <= '0;
    frames.payload_size   <= '0;
    frames.payload_word0  <= '0;
    frames.payload_word1  <= '0;
    frames.payload_word2  <= '0;
    frames.payload_tail   <= '0;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= REG_DROP_BROKEN;
    cfg_data              <= '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: prefixes of broken blocks are visible
    set_config(1'b0, 10'd512);
    // block 0 right after reset: zero expected fragments, completes empty
    send_frag(8'd0, 8'd0, 8'd3, 8'd4);
    send_frag(8'd0, 8'd1, 8'd3, 8'd4);
    // single fragment, oversized, all ones, then its repeat
    send_frame(8'd5, 8'd0, 8'd1, 8'd255, '1, '1, '1, '1);
    send_frag(8'd5, 8'd0, 8'd1, 8'd20);
    // single fragment with no payload
    send_frag(8'd6, 8'd0, 8'd1, 8'd0);
    // clean three-fragment block, then a late repeat
    send_frame(8'd7, 8'd0, 8'd3, 8'd28, '0, '0, '0, '0);
    send_frag(8'd7, 8'd1, 8'd3, 8'd1);
    send_frag(8'd7, 8'd2, 8'd3, 8'd13);
    send_frag(8'd7, 8'd2, 8'd3, 8'd13);
    // middle fragment missing
    send_frag(8'd8, 8'd0, 8'd3, 8'd8);
    send_frag(8'd8, 8'd2, 8'd3, 8'd8);
    // index past the store, then an empty first fragment
    send_frag(8'd9, 8'd200, 8'd2, 8'd10);
    send_frag(8'd9, 8'd0, 8'd2, 8'd0);
    send_frag(8'd9, 8'd1, 8'd2, 8'd5);
    // final index overshot
    send_frag(8'd10, 8'd0, 8'd2, 8'd3);
    send_frag(8'd10, 8'd5, 8'd2, 8'd7);
    // highest block number, zero fragments expected
    send_frag(8'd255, 8'd3, 8'd0, 8'd5);
    send_frag(8'd255, 8'd0, 8'd0, 8'd5);
    // total that can never complete
    send_frag(8'd254, 8'd255, 8'd255, 8'd28);
    send_frag(8'd254, 8'd15, 8'd255, 8'd28);
    // fragments out of order
    send_frag(8'd253, 8'd1, 8'd2, 8'd28);
    send_frag(8'd253, 8'd0, 8'd2, 8'd17);
    settle();

    // Random phases across settings and idle patterns
    next_block = HDR_W'($urandom);
    for (p = 0; p < 7; p++) begin
      case (p)
        0: set_config(1'b1, 10'd512);
        1: set_config(1'b0, 10'd1);
        2: set_config(1'b1, 10'd1);
        3: set_config(1'b0, CFG_DATA_W'($urandom_range(40, 160)));
        4: set_config(1'b1, CFG_DATA_W'($urandom_range(40, 160)));
        5: set_config(1'b0, 10'd511);
        default: set_config(1'b1, 10'd300);
      endcase
      idle_mode = modes[p % 4];
      run_random(PHASE_ITEMS);
      settle();
    end

    // Long output hold-off while full blocks keep arriving
    set_config(1'b0, 10'd512);
    idle_mode = IDLE_NONE;
    hold_req  = 1'b1;
    for (p = 0; p < 3; p++) begin
      next_block++;
      send_block(next_block, MAX_FRAGMENTS, FLAW_NONE);
    end
    settle();

    if (fail_count == 0 && pending_words == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
